### design/max_flow_edmonds_karp_macros.svh
// Assertion macros for the max-flow block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef MAX_FLOW_EDMONDS_KARP_MACROS_SVH
`define MAX_FLOW_EDMONDS_KARP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MFEK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define MFEK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mfek_pkg.sv
// Shared types and constants for the max-flow block.
// No dependencies.
`default_nettype none

package mfek_pkg;

  localparam int NODE_W     = 6;
  localparam int LINK_W     = 16;
  localparam int CAP_W      = 18;
  localparam int FLOW_W     = 22;
  localparam int USED_W     = 32;
  localparam int CMPW       = NODE_W + 1;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(32);
  localparam logic [CAP_W-1:0]  CAP_MAX        = '1;
  localparam logic [FLOW_W-1:0] FLOW_MAX       = '1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_RUN   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINIT,
    ST_POP,
    ST_RD,
    ST_EV,
    ST_AF,
    ST_AB,
    ST_WF,
    ST_WB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic link_wr;
    logic clr_init;
    logic clr_step;
    logic run_load;
    logic search_init;
    logic pop;
    logic scan_rd;
    logic scan_ev;
    logic aug_rdf;
    logic aug_rdb;
    logic aug_wrf;
    logic aug_wrb;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ep_ok;
    logic queue_empty;
    logic scan_end;
    logic hit_dst;
    logic walk_end;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### design/mfek_in_if.sv
// Input channel: valid/ready with command payload.
// Depends on mfek_pkg.
`default_nettype none

interface mfek_in_if;
  import mfek_pkg::*;

  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [NODE_W-1:0]   from_node;
  logic [NODE_W-1:0]   to_node;
  logic [LINK_W-1:0]   link_capacity;
  logic [NODE_W-1:0]   source_node;
  logic [NODE_W-1:0]   sink_node;
  logic [FLOW_W-1:0]   min_total;

  modport source (output valid, cmd, from_node, to_node, link_capacity, source_node,
                  sink_node, min_total, input ready);
  modport sink   (input valid, cmd, from_node, to_node, link_capacity, source_node,
                  sink_node, min_total, output ready);
endinterface

`default_nettype wire

### design/mfek_out_if.sv
// Result channel: valid/ready with flow and node mask.
// Depends on mfek_pkg.
`default_nettype none

interface mfek_out_if;
  import mfek_pkg::*;

  logic                valid;
  logic                ready;
  logic [FLOW_W-1:0]   total_flow;
  logic [USED_W-1:0]   used_nodes;

  modport source (output valid, total_flow, used_nodes, input ready);
  modport sink   (input valid, total_flow, used_nodes, output ready);
endinterface

`default_nettype wire

### design/mfek_ram.sv
// Generic RAM, one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module mfek_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### design/mfek_ctrl.sv
// Sequencer for clear sweep, link writes, BFS search and path augmentation.
// Depends on mfek_pkg.
`default_nettype none

module mfek_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire mfek_pkg::cmd_t     in_cmd,
  output      logic               in_ready,
  input  wire mfek_pkg::ctrl_sts_t sts,
  output      mfek_pkg::ctrl_cmd_t cmd
);
  import mfek_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_ADD: cmd.link_wr = 1'b1;
            CMD_RUN: begin
              cmd.run_load = 1'b1;
              state_nxt    = ST_SINIT;
            end
            CMD_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_SINIT: begin
        if (!sts.ep_ok) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.search_init = 1'b1;
          state_nxt       = ST_POP;
        end
      end
      ST_POP: begin
        if (sts.queue_empty) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.scan_end) begin
          state_nxt = ST_POP;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_EV;
        end
      end
      ST_EV: begin
        cmd.scan_ev = 1'b1;
        state_nxt   = sts.hit_dst ? ST_AF : ST_RD;
      end
      ST_AF: begin
        cmd.aug_rdf = 1'b1;
        state_nxt   = ST_AB;
      end
      ST_AB: begin
        cmd.aug_rdb = 1'b1;
        state_nxt   = ST_WF;
      end
      ST_WF: begin
        cmd.aug_wrf = 1'b1;
        state_nxt   = ST_WB;
      end
      ST_WB: begin
        cmd.aug_wrb = 1'b1;
        state_nxt   = sts.walk_end ? ST_SINIT : ST_AF;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/mfek_dpath.sv
// Datapath: residual matrix RAM, BFS queue, parents, flow and result register.
// Depends on mfek_pkg and mfek_ram.
`default_nettype none

module mfek_dpath #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [mfek_pkg::NODE_W-1:0] cfg_wdata,
  input  wire mfek_pkg::ctrl_cmd_t         cmd,
  output      mfek_pkg::ctrl_sts_t         sts,
  input  wire logic [mfek_pkg::NODE_W-1:0] from_node,
  input  wire logic [mfek_pkg::NODE_W-1:0] to_node,
  input  wire logic [mfek_pkg::LINK_W-1:0] link_capacity,
  input  wire logic [mfek_pkg::NODE_W-1:0] source_node,
  input  wire logic [mfek_pkg::NODE_W-1:0] sink_node,
  input  wire logic [mfek_pkg::FLOW_W-1:0] min_total,
  input  wire logic                        out_ready,
  output      logic                        out_valid,
  output      logic [mfek_pkg::FLOW_W-1:0] out_total,
  output      logic [mfek_pkg::USED_W-1:0] out_used
);
  import mfek_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] cell_addr(logic [NW-1:0] row, logic [NW-1:0] col);
    return AW'(row) * AW'(MAX_NODES) + AW'(col);
  endfunction

  function automatic logic [NW-1:0] to_idx(logic [NODE_W-1:0] v);
    logic [NODE_W-1:0] m;
    m = v - NODE_W'(1);
    return m[NW-1:0];
  endfunction

  logic [NODE_W-1:0] node_count_r;
  logic [AW-1:0]     clr_addr_r;
  logic [NW-1:0]     src_r, dst_r, cur_r, walk_r;
  logic [FLOW_W-1:0] need_r, flow_r;
  logic              ep_ok_r;
  logic [MAX_NODES-1:0] mask_r, visited_r;
  logic [NW-1:0]     parent_r [MAX_NODES];
  logic [NW-1:0]     q_node_r [MAX_NODES];
  logic [CAP_W-1:0]  q_neck_r [MAX_NODES];
  logic [CW-1:0]     head_r, tail_r;
  logic [CAP_W-1:0]  neck_r, f_r, fwd_r, back_r;
  logic [CMPW-1:0]   nx_r;
  logic              out_valid_r;
  logic [FLOW_W-1:0] out_total_r;
  logic [USED_W-1:0] out_used_r;

  logic [CMPW-1:0]   n_eff;
  logic              link_ok, run_ok;
  logic [NW-1:0]     nx_idx, prev;
  logic [CAP_W-1:0]  rdata, nn;
  logic              cand;
  logic [FLOW_W:0]   fsum;
  logic [CAP_W:0]    bsum;
  logic [CAP_W-1:0]  bsat;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [CAP_W-1:0]  wdata;
  logic [USED_W-1:0] used_w;

  assign n_eff = (CMPW'(node_count_r) > CMPW'(MAX_NODES)) ? CMPW'(MAX_NODES)
                                                           : CMPW'(node_count_r);
  assign link_ok = (from_node != '0) && (CMPW'(from_node) <= n_eff) &&
                   (to_node != '0) && (CMPW'(to_node) <= n_eff);
  assign run_ok  = (source_node != '0) && (CMPW'(source_node) <= n_eff) &&
                   (sink_node != '0) && (CMPW'(sink_node) <= n_eff);

  assign nx_idx = nx_r[NW-1:0];
  assign prev   = parent_r[walk_r];
  assign cand   = !visited_r[nx_idx] && (rdata != '0);
  assign nn     = (neck_r < rdata) ? neck_r : rdata;
  assign fsum   = {1'b0, flow_r} + (FLOW_W+1)'(nn);
  assign bsum   = {1'b0, back_r} + {1'b0, f_r};
  assign bsat   = bsum[CAP_W] ? CAP_MAX : bsum[CAP_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_r;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.link_wr && link_ok) begin
      we    = 1'b1;
      waddr = cell_addr(to_idx(from_node), to_idx(to_node));
      wdata = CAP_W'(link_capacity);
    end else if (cmd.aug_wrf) begin
      we    = 1'b1;
      waddr = cell_addr(prev, walk_r);
      wdata = fwd_r - f_r;
    end else if (cmd.aug_wrb) begin
      we    = 1'b1;
      waddr = cell_addr(walk_r, prev);
      wdata = bsat;
    end
  end

  always_comb begin
    if (cmd.aug_rdf) begin
      raddr = cell_addr(prev, walk_r);
    end else if (cmd.aug_rdb) begin
      raddr = cell_addr(walk_r, prev);
    end else begin
      raddr = cell_addr(cur_r, nx_idx);
    end
  end

  mfek_ram #(.WIDTH(CAP_W), .DEPTH(DEPTH)) u_res (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      if (cmd.clr_init) begin
        clr_addr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // search and augment state
  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      src_r   <= to_idx(source_node);
      dst_r   <= to_idx(sink_node);
      need_r  <= min_total;
      ep_ok_r <= run_ok;
      flow_r  <= '0;
      mask_r  <= '0;
    end
    if (cmd.search_init) begin
      visited_r   <= MAX_NODES'(1) << src_r;
      q_node_r[0] <= src_r;
      q_neck_r[0] <= CAP_MAX;
      head_r      <= '0;
      tail_r      <= CW'(1);
    end
    if (cmd.pop) begin
      cur_r  <= q_node_r[head_r[NW-1:0]];
      neck_r <= q_neck_r[head_r[NW-1:0]];
      head_r <= head_r + CW'(1);
      nx_r   <= '0;
    end
    if (cmd.scan_ev) begin
      nx_r <= nx_r + CMPW'(1);
      if (cand) begin
        visited_r[nx_idx] <= 1'b1;
        parent_r[nx_idx]  <= cur_r;
        if (nx_idx == dst_r) begin
          f_r    <= nn;
          walk_r <= dst_r;
          flow_r <= fsum[FLOW_W] ? FLOW_MAX : fsum[FLOW_W-1:0];
        end else if (tail_r < CW'(MAX_NODES)) begin
          q_node_r[tail_r[NW-1:0]] <= nx_idx;
          q_neck_r[tail_r[NW-1:0]] <= nn;
          tail_r                   <= tail_r + CW'(1);
        end
      end
    end
    if (cmd.aug_rdb) fwd_r  <= rdata;
    if (cmd.aug_wrf) back_r <= rdata;
    if (cmd.aug_wrb) begin
      mask_r[prev] <= 1'b1;
      walk_r       <= prev;
    end
    if (cmd.result_load) begin
      if (flow_r < need_r) begin
        out_total_r <= '0;
        out_used_r  <= '0;
      end else begin
        out_total_r <= flow_r;
        out_used_r  <= used_w;
      end
    end
  end

  // nodes beyond the mask width are dropped
  for (genvar i = 0; i < USED_W; i++) begin : g_used
    if (i < MAX_NODES) begin : g_on
      assign used_w[i] = mask_r[i];
    end else begin : g_off
      assign used_w[i] = 1'b0;
    end
  end

  assign sts.clr_last    = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.ep_ok       = ep_ok_r;
  assign sts.queue_empty = (head_r == tail_r);
  assign sts.scan_end    = (nx_r == n_eff);
  assign sts.hit_dst     = cand && (nx_idx == dst_r);
  assign sts.walk_end    = (prev == src_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;
  assign out_used  = out_used_r;

endmodule

`default_nettype wire

### design/max_flow_edmonds_karp.sv
// Edmonds-Karp maximum flow over a residual capacity matrix held in one RAM
// of MAX_NODES*MAX_NODES 18-bit cells. After reset, and after every clear
// command, the block sweeps the RAM to zero one cell per cycle and accepts
// no item meanwhile. Add-link items are taken one per cycle. A run item
// holds off input until its result is in the output register: each
// breadth-first search has a setup step, a pop and an end-of-scan check per
// dequeued node plus one RAM read and one evaluate per scanned neighbor, and
// a final check when the queue runs dry; a scan that reaches the sink stops
// there. Each edge of an augmenting path takes two reads and two writes on
// the single RAM port pair, and the result load waits until the output
// register is free. The result register lets the next item enter while a
// result waits. node_count is written through cfg_we/cfg_wdata, and only
// while idle: the user must keep to this, the block does not enforce it.
// Depends on mfek_pkg, mfek_in_if, mfek_out_if, mfek_ctrl, mfek_dpath.
`default_nettype none
`include "max_flow_edmonds_karp_macros.svh"

module max_flow_edmonds_karp #(
  parameter int MAX_NODES = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [mfek_pkg::NODE_W-1:0] cfg_wdata,
  mfek_in_if.sink                          in_chan,
  mfek_out_if.source                       out_chan
);
  import mfek_pkg::*;

  ctrl_cmd_t ctl_cmd;
  ctrl_sts_t ctl_sts;
  logic      in_ready;

  mfek_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_cmd   (in_chan.cmd),
    .in_ready (in_ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  mfek_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (ctl_cmd),
    .sts           (ctl_sts),
    .from_node     (in_chan.from_node),
    .to_node       (in_chan.to_node),
    .link_capacity (in_chan.link_capacity),
    .source_node   (in_chan.source_node),
    .sink_node     (in_chan.sink_node),
    .min_total     (in_chan.min_total),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_total     (out_chan.total_flow),
    .out_used      (out_chan.used_nodes)
  );

  assign in_chan.ready = in_ready;

  `MFEK_ASSERT_NEXT(a_run_blocks_input, ctl_cmd.run_load, !in_ready, "input taken during run")
  `MFEK_ASSERT_NOW(a_result_slot_free, ctl_cmd.result_load,
                   !out_chan.valid || out_chan.ready, "result overwrote pending transfer")
  `MFEK_ASSERT_NOW(a_zero_flow_no_mask, out_chan.valid && (out_chan.total_flow == '0),
                   out_chan.used_nodes == '0, "node mask set with zero flow")

endmodule

`default_nettype wire
